[rtl/core/sdspi_pkg.sv]
// Shared types, codes and command frame tables for the SD SPI sequencer.
`timescale 1ns / 1ps

package sdspi_pkg;

	// Item modes
	localparam logic [2:0] MODE_REPLY = 3'd0;
	localparam logic [2:0] MODE_INIT  = 3'd1;
	localparam logic [2:0] MODE_WRITE = 3'd2;
	localparam logic [2:0] MODE_DATA  = 3'd3;
	localparam logic [2:0] MODE_END   = 3'd4;

	// Status codes
	localparam logic [2:0] STAT_IDLE     = 3'd0;
	localparam logic [2:0] STAT_BUSY     = 3'd1;
	localparam logic [2:0] STAT_CMD0_ERR = 3'd2;
	localparam logic [2:0] STAT_TIMEOUT  = 3'd3;
	localparam logic [2:0] STAT_REFUSED  = 3'd4;

	// Configuration register indexes
	localparam logic CFG_RETRY_LIMIT = 1'b0;
	localparam logic CFG_WAKE_WORDS  = 1'b1;

	// Configuration reset values
	localparam logic [15:0] RETRY_LIMIT_RST = 16'd16384;
	localparam logic [7:0]  WAKE_WORDS_RST  = 8'd100;

	// Protocol words
	localparam logic [15:0] WORD_IDLE    = 16'hFFFF;
	localparam logic [15:0] WORD_R1_IDLE = 16'hFF01;
	localparam logic [15:0] WORD_STOP    = 16'hFDFF;

	typedef enum logic [4:0] {
		PH_IDLE      = 5'd0,
		PH_WAKE      = 5'd1,
		PH_CMD0      = 5'd2,
		PH_CMD0_BAD  = 5'd3,
		PH_CMD8      = 5'd4,
		PH_CMD58A    = 5'd5,
		PH_CMD55     = 5'd6,
		PH_ACMD41    = 5'd7,
		PH_ACMD_DONE = 5'd8,
		PH_CMD58B    = 5'd9,
		PH_CMD25     = 5'd10,
		PH_DATAWAIT  = 5'd11,
		PH_DATA      = 5'd12,
		PH_CRC       = 5'd13,
		PH_BUSY1     = 5'd14,
		PH_STOP      = 5'd15,
		PH_BUSY2     = 5'd16
	} phase_t;

	typedef enum logic [2:0] {
		FR_CMD0   = 3'd0,
		FR_CMD8   = 3'd1,
		FR_CMD58  = 3'd2,
		FR_CMD55  = 3'd3,
		FR_ACMD41 = 3'd4,
		FR_CMD25  = 3'd5,
		FR_CRC    = 3'd6,
		FR_NONE   = 3'd7
	} frame_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [15:0] word;
	} item_t;

	typedef struct packed {
		logic        tx_valid;
		logic [15:0] tx_word;
		logic        select_high;
		logic        fast_clock;
		logic [2:0]  status;
	} result_t;

	typedef struct packed {
		phase_t      phase;
		logic [2:0]  word_index;
		logic [15:0] attempt_count;
		logic [7:0]  wake_count;
		logic [15:0] address_low;
		logic [2:0]  status_code;
		logic        fast_flag;
		logic        select_level;
	} state_t;

	// Frame words, one row per frame; the last row is unused
	localparam logic [0:7][0:7][15:0] FRAME_WORDS = {
		{16'h4000, 16'h0000, 16'h0095, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000},
		{16'h4800, 16'h0001, 16'hAA87, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000},
		{16'h7A00, 16'h0001, 16'h00FD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000},
		{16'h7700, 16'h0000, 16'h0065, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000},
		{16'h6940, 16'h0000, 16'h0077, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000},
		{16'h5900, 16'h0080, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFCAD},
		{16'h0000, 16'h00FF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
		{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}
	};

	function automatic logic [15:0] frame_word(frame_t f, logic [2:0] i);
		return FRAME_WORDS[f][i];
	endfunction

	function automatic logic [3:0] frame_len(frame_t f);
		logic [3:0] len;
		case (f)
			FR_CMD0:   len = 4'd5;
			FR_CMD8:   len = 4'd7;
			FR_CMD58:  len = 4'd7;
			FR_CMD55:  len = 4'd5;
			FR_ACMD41: len = 4'd5;
			FR_CMD25:  len = 4'd8;
			FR_CRC:    len = 4'd4;
			default:   len = 4'd0;
		endcase
		return len;
	endfunction

	function automatic frame_t frame_of(phase_t ph);
		frame_t f;
		case (ph)
			PH_CMD0, PH_CMD0_BAD:   f = FR_CMD0;
			PH_CMD8:                f = FR_CMD8;
			PH_CMD58A, PH_CMD58B:   f = FR_CMD58;
			PH_CMD55:               f = FR_CMD55;
			PH_ACMD41, PH_ACMD_DONE: f = FR_ACMD41;
			PH_CMD25:               f = FR_CMD25;
			PH_CRC:                 f = FR_CRC;
			default:                f = FR_NONE;
		endcase
		return f;
	endfunction

endpackage

[rtl/core/sd_spi_init_and_write_sequencer.sv]
// Top level of the SD card SPI-mode init and multi-block write sequencer.
`timescale 1ns / 1ps

// SD card SPI-mode host sequencer working in 16-bit lockstep words. Each item
// (a received word, a start of init or write, a data word or an end of write)
// yields exactly one result giving the next word to send, if any, and the chip
// select, clock speed and status levels. One item is accepted every cycle while
// in_stall is low; each item is held in the input register, then the step logic
// updates the phase machine and loads the item's result into the result register,
// from which it is transferred out. Input stall rises only while the result register
// is full and its transfer is stalled. Configuration writes take effect on the
// next cycle and no clearing pass is needed after reset.
module sd_spi_init_and_write_sequencer import sdspi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  mode,
	input  logic [15:0] word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        tx_valid,
	output logic [15:0] tx_word,
	output logic        select_high,
	output logic        fast_clock,
	output logic [2:0]  status
);

	item_t   in_item;
	item_t   item_s1;
	logic    valid_s1;
	logic    take;
	result_t res;
	result_t res_q;

	assign in_item.mode = mode;
	assign in_item.word = word;

	sdspi_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_item  (in_item),
		.take     (take),
		.stall    (in_stall),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	sdspi_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.take      (take),
		.item_s1   (item_s1),
		.res       (res)
	);

	sdspi_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.res       (res),
		.out_stall (out_stall),
		.take      (take),
		.out_valid (out_valid),
		.res_q     (res_q)
	);

	// Result fields
	assign tx_valid    = res_q.tx_valid;
	assign tx_word     = res_q.tx_word;
	assign select_high = res_q.select_high;
	assign fast_clock  = res_q.fast_clock;
	assign status      = res_q.status;

endmodule

[rtl/core/sdspi_in_reg.sv]
// Input register stage of the SD SPI sequencer.
`timescale 1ns / 1ps

module sdspi_in_reg import sdspi_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  item_t      in_item,
	input  logic       take,
	output logic       stall,
	output logic       valid_s1,
	output item_t      item_s1
);

	// Hold while the registered item cannot move on
	assign stall = valid_s1 && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload, no reset
	always_ff @(posedge clk) begin
		if (!stall && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

[rtl/core/sdspi_core.sv]
// Sequencer state, configuration registers and combinational step logic.
`timescale 1ns / 1ps

module sdspi_core import sdspi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        take,
	input  item_t       item_s1,
	output result_t     res
);

	state_t      st_q;
	state_t      nx;
	logic [15:0] retry_limit_q;
	logic [7:0]  wake_words_q;
	logic        tx_on;
	logic [15:0] tx_val;
	logic        refused;
	logic        running;
	frame_t      f;
	phase_t      ph;
	logic [3:0]  nidx;
	logic [15:0] cnt;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q <= RETRY_LIMIT_RST;
			wake_words_q  <= WAKE_WORDS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RETRY_LIMIT: retry_limit_q <= cfg_data;
				CFG_WAKE_WORDS:  wake_words_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase         <= PH_IDLE;
			st_q.word_index    <= '0;
			st_q.attempt_count <= '0;
			st_q.wake_count    <= '0;
			st_q.address_low   <= '0;
			st_q.status_code   <= STAT_IDLE;
			st_q.fast_flag     <= 1'b0;
			st_q.select_level  <= 1'b1;
		end else if (take) begin
			st_q <= nx;
		end
	end

	assign running = !(st_q.phase inside {PH_IDLE, PH_DATAWAIT});

	// Next state and result for one item
	always_comb begin
		nx      = st_q;
		tx_on   = 1'b0;
		tx_val  = '0;
		refused = 1'b0;
		f       = frame_of(st_q.phase);
		ph      = st_q.phase;
		nidx    = {1'b0, st_q.word_index} + 4'd1;
		cnt     = st_q.attempt_count + 16'd1;
		case (item_s1.mode)
			MODE_REPLY: begin
				if (running) begin
					case (st_q.phase)
						PH_WAKE: begin
							tx_on = 1'b1;
							if (st_q.wake_count >= wake_words_q) begin
								nx.select_level = 1'b0;
								nx.phase        = PH_CMD0;
								nx.word_index   = '0;
								tx_val          = frame_word(FR_CMD0, 3'd0);
							end else begin
								nx.wake_count = st_q.wake_count + 8'd1;
								tx_val        = WORD_IDLE;
							end
						end
						PH_BUSY1, PH_BUSY2: begin
							if (item_s1.word == WORD_IDLE) begin
								if (st_q.phase == PH_BUSY1) begin
									nx.phase = PH_STOP;
									tx_on    = 1'b1;
									tx_val   = WORD_STOP;
								end else begin
									nx.phase       = PH_IDLE;
									nx.status_code = STAT_IDLE;
								end
							end else begin
								nx.attempt_count = cnt;
								if (cnt >= retry_limit_q) begin
									nx.phase       = PH_IDLE;
									nx.word_index  = '0;
									nx.status_code = STAT_TIMEOUT;
								end else begin
									tx_on  = 1'b1;
									tx_val = WORD_IDLE;
								end
							end
						end
						PH_STOP: begin
							nx.phase         = PH_BUSY2;
							nx.attempt_count = '0;
							tx_on            = 1'b1;
							tx_val           = WORD_IDLE;
						end
						PH_DATA: begin
							nx.phase = PH_DATAWAIT;
						end
						default: begin
							if (f == FR_NONE) begin
								nx.phase       = PH_IDLE;
								nx.word_index  = '0;
								nx.status_code = STAT_IDLE;
							end else begin
								// R1 check on the first poll of CMD0 and ACMD41
								if (st_q.word_index == 3'd3 && item_s1.word != WORD_R1_IDLE) begin
									if (ph == PH_CMD0) begin
										ph = PH_CMD0_BAD;
									end else if (ph == PH_ACMD41) begin
										ph = PH_ACMD_DONE;
									end
								end
								nx.phase = ph;
								if (nidx < frame_len(f)) begin
									nx.word_index = nidx[2:0];
									tx_on         = 1'b1;
									if (f == FR_CMD25 && nidx == 4'd2) begin
										tx_val = st_q.address_low;
									end else begin
										tx_val = frame_word(f, nidx[2:0]);
									end
								end else begin
									// End of frame
									nx.word_index = '0;
									case (ph)
										PH_CMD0: begin
											nx.phase = PH_CMD8;
											tx_on    = 1'b1;
											tx_val   = frame_word(FR_CMD8, 3'd0);
										end
										PH_CMD0_BAD: begin
											nx.phase       = PH_IDLE;
											nx.status_code = STAT_CMD0_ERR;
										end
										PH_CMD8: begin
											nx.phase = PH_CMD58A;
											tx_on    = 1'b1;
											tx_val   = frame_word(FR_CMD58, 3'd0);
										end
										PH_CMD58A: begin
											nx.attempt_count = '0;
											nx.phase         = PH_CMD55;
											tx_on            = 1'b1;
											tx_val           = frame_word(FR_CMD55, 3'd0);
										end
										PH_CMD55: begin
											nx.phase = PH_ACMD41;
											tx_on    = 1'b1;
											tx_val   = frame_word(FR_ACMD41, 3'd0);
										end
										PH_ACMD41: begin
											nx.attempt_count = cnt;
											if (cnt >= retry_limit_q) begin
												nx.phase       = PH_IDLE;
												nx.status_code = STAT_TIMEOUT;
											end else begin
												nx.phase = PH_CMD55;
												tx_on    = 1'b1;
												tx_val   = frame_word(FR_CMD55, 3'd0);
											end
										end
										PH_ACMD_DONE: begin
											nx.phase = PH_CMD58B;
											tx_on    = 1'b1;
											tx_val   = frame_word(FR_CMD58, 3'd0);
										end
										PH_CMD58B: begin
											nx.phase       = PH_IDLE;
											nx.fast_flag   = 1'b1;
											nx.status_code = STAT_IDLE;
										end
										PH_CMD25: begin
											nx.phase = PH_DATAWAIT;
										end
										PH_CRC: begin
											nx.phase         = PH_BUSY1;
											nx.attempt_count = '0;
											tx_on            = 1'b1;
											tx_val           = WORD_IDLE;
										end
										default: begin
											nx.phase       = PH_IDLE;
											nx.status_code = STAT_IDLE;
										end
									endcase
								end
							end
						end
					endcase
				end
			end
			MODE_INIT, MODE_WRITE: begin
				if (st_q.phase == PH_IDLE) begin
					nx.status_code   = STAT_BUSY;
					nx.attempt_count = '0;
					nx.word_index    = '0;
					tx_on            = 1'b1;
					if (item_s1.mode == MODE_INIT) begin
						nx.fast_flag    = 1'b0;
						nx.select_level = 1'b1;
						nx.wake_count   = 8'd1;
						nx.phase        = PH_WAKE;
						tx_val          = WORD_IDLE;
					end else begin
						nx.address_low = item_s1.word;
						nx.phase       = PH_CMD25;
						tx_val         = frame_word(FR_CMD25, 3'd0);
					end
				end else begin
					refused = 1'b1;
				end
			end
			MODE_DATA, MODE_END: begin
				if (st_q.phase == PH_DATAWAIT) begin
					tx_on = 1'b1;
					if (item_s1.mode == MODE_DATA) begin
						nx.phase = PH_DATA;
						tx_val   = item_s1.word;
					end else begin
						nx.phase      = PH_CRC;
						nx.word_index = '0;
						tx_val        = frame_word(FR_CRC, 3'd0);
					end
				end else begin
					refused = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Result fields
	assign res.tx_valid    = tx_on;
	assign res.tx_word     = tx_val;
	assign res.select_high = nx.select_level;
	assign res.fast_clock  = nx.fast_flag;
	assign res.status      = refused ? STAT_REFUSED : nx.status_code;

	// Chip select is never high during the init command frames
	a_select_phase: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.select_level |-> !(st_q.phase >= PH_CMD0 && st_q.phase <= PH_CMD58B))
		else $error("chip select high during an init command frame");

	// Word index only runs inside command frames
	a_index_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase == PH_IDLE || st_q.phase == PH_WAKE || st_q.phase == PH_DATAWAIT ||
		 st_q.phase == PH_DATA || st_q.phase == PH_BUSY1 || st_q.phase == PH_STOP ||
		 st_q.phase == PH_BUSY2) |-> st_q.word_index == 3'd0)
		else $error("word index set outside a frame");

	// A refused command leaves the state alone
	a_refused_stable: assert property (@(posedge clk) disable iff (!arst_n)
		take && refused |=> $stable(st_q))
		else $error("refused command changed state");

endmodule

[rtl/core/sdspi_out_reg.sv]
// Result register of the SD SPI sequencer.
`timescale 1ns / 1ps

module sdspi_out_reg import sdspi_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    valid_s1,
	input  result_t res,
	input  logic    out_stall,
	output logic    take,
	output logic    out_valid,
	output result_t res_q
);

	// Accept a new result when empty or when the held one is transferred
	assign take = valid_s1 && (!out_valid || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= take || (out_valid && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res;
		end
	end

endmodule

[tb/tb_sd_spi_init_and_write_sequencer.sv]
// Self-checking testbench for the SD SPI init and multi-block write sequencer.
`timescale 1ns / 1ps

module tb_sd_spi_init_and_write_sequencer;
	import sdspi_pkg::*;

	// Modes the block does not use; they must change nothing
	localparam logic [2:0] MODE_UNUSED_5 = 3'd5;
	localparam logic [2:0] MODE_UNUSED_6 = 3'd6;
	localparam logic [2:0] MODE_UNUSED_7 = 3'd7;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 60;
	localparam int REPORT_MAX  = 10;

	// Sequencer behaviour predictor and store of expected results
	class sd_seq_scoreboard;
		logic [15:0] retry_limit;
		logic [7:0]  wake_words;
		phase_t      phase;
		logic [2:0]  word_index;
		logic [15:0] attempt_count;
		logic [7:0]  wake_count;
		logic [15:0] address_low;
		logic [2:0]  status_code;
		logic        fast_flag;
		logic        select_level;
		logic        tx_on;
		logic [15:0] tx_val;
		result_t     expected_q[$];
		int          mismatches;
		int          checked;
		int          refusals;
		int          inits_done;
		int          cmd0_errors;
		int          timeouts;

		function new();
			retry_limit   = RETRY_LIMIT_RST;
			wake_words    = WAKE_WORDS_RST;
			phase         = PH_IDLE;
			word_index    = '0;
			attempt_count = '0;
			wake_count    = '0;
			address_low   = '0;
			status_code   = STAT_IDLE;
			fast_flag     = 1'b0;
			select_level  = 1'b1;
			mismatches    = 0;
			checked       = 0;
			refusals      = 0;
			inits_done    = 0;
			cmd0_errors   = 0;
			timeouts      = 0;
		endfunction

		function void set_reg(logic idx, logic [15:0] value);
			if (idx == CFG_RETRY_LIMIT) begin
				retry_limit = value;
			end else begin
				wake_words = value[7:0];
			end
		endfunction

		// A word is in flight whenever a sequence runs
		function bit running();
			return phase != PH_IDLE && phase != PH_DATAWAIT;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function frame_t frame_for(phase_t ph);
			case (ph)
				PH_CMD0, PH_CMD0_BAD:    return FR_CMD0;
				PH_CMD8:                 return FR_CMD8;
				PH_CMD58A, PH_CMD58B:    return FR_CMD58;
				PH_CMD55:                return FR_CMD55;
				PH_ACMD41, PH_ACMD_DONE: return FR_ACMD41;
				PH_CMD25:                return FR_CMD25;
				PH_CRC:                  return FR_CRC;
				default:                 return FR_NONE;
			endcase
		endfunction

		// Command frames: three command words, then polls (CMD25 ends on the token)
		function logic [15:0] frame_word_at(frame_t f, int i);
			logic [15:0] w;
			w = 16'h0000;
			case (f)
				FR_CMD0: case (i)
					0: w = 16'h4000;
					2: w = 16'h0095;
					3, 4: w = WORD_IDLE;
					default: ;
				endcase
				FR_CMD8: case (i)
					0: w = 16'h4800;
					1: w = 16'h0001;
					2: w = 16'hAA87;
					3, 4, 5, 6: w = WORD_IDLE;
					default: ;
				endcase
				FR_CMD58: case (i)
					0: w = 16'h7A00;
					1: w = 16'h0001;
					2: w = 16'h00FD;
					3, 4, 5, 6: w = WORD_IDLE;
					default: ;
				endcase
				FR_CMD55: case (i)
					0: w = 16'h7700;
					2: w = 16'h0065;
					3, 4: w = WORD_IDLE;
					default: ;
				endcase
				FR_ACMD41: case (i)
					0: w = 16'h6940;
					2: w = 16'h0077;
					3, 4: w = WORD_IDLE;
					default: ;
				endcase
				FR_CMD25: case (i)
					0: w = 16'h5900;
					1: w = 16'h0080;
					2: w = address_low;
					3, 4, 5, 6: w = WORD_IDLE;
					7: w = 16'hFCAD;
					default: ;
				endcase
				FR_CRC: case (i)
					1: w = 16'h00FF;
					2, 3: w = WORD_IDLE;
					default: ;
				endcase
				default: ;
			endcase
			return w;
		endfunction

		function int frame_words_in(frame_t f);
			case (f)
				FR_CMD0, FR_CMD55, FR_ACMD41: return 5;
				FR_CMD8, FR_CMD58:            return 7;
				FR_CMD25:                     return 8;
				FR_CRC:                       return 4;
				default:                      return 0;
			endcase
		endfunction

		function void send(logic [15:0] w);
			tx_on  = 1'b1;
			tx_val = w;
		endfunction

		function void start_frame(phase_t ph);
			phase      = ph;
			word_index = '0;
			send(frame_word_at(frame_for(ph), 0));
		endfunction

		function void abort_with(logic [2:0] code);
			phase       = PH_IDLE;
			word_index  = '0;
			status_code = code;
			if (code == STAT_CMD0_ERR) cmd0_errors++;
			if (code == STAT_TIMEOUT) timeouts++;
		endfunction

		// Last word of a frame answered
		function void frame_done();
			case (phase)
				PH_CMD0:     start_frame(PH_CMD8);
				PH_CMD0_BAD: abort_with(STAT_CMD0_ERR);
				PH_CMD8:     start_frame(PH_CMD58A);
				PH_CMD58A: begin
					attempt_count = '0;
					start_frame(PH_CMD55);
				end
				PH_CMD55:    start_frame(PH_ACMD41);
				PH_ACMD41: begin
					attempt_count = attempt_count + 16'd1;
					if (attempt_count >= retry_limit) begin
						abort_with(STAT_TIMEOUT);
					end else begin
						start_frame(PH_CMD55);
					end
				end
				PH_ACMD_DONE: start_frame(PH_CMD58B);
				PH_CMD58B: begin
					phase       = PH_IDLE;
					word_index  = '0;
					fast_flag   = 1'b1;
					status_code = STAT_IDLE;
					inits_done++;
				end
				PH_CMD25: begin
					phase      = PH_DATAWAIT;
					word_index = '0;
				end
				PH_CRC: begin
					phase         = PH_BUSY1;
					word_index    = '0;
					attempt_count = '0;
					send(WORD_IDLE);
				end
				default: abort_with(STAT_IDLE);
			endcase
		endfunction

		// Card busy wait: poll until the line reads all ones or the retry limit is reached
		function void busy_reply(logic [15:0] w);
			if (w == WORD_IDLE) begin
				if (phase == PH_BUSY1) begin
					phase = PH_STOP;
					send(WORD_STOP);
				end else begin
					phase       = PH_IDLE;
					status_code = STAT_IDLE;
				end
				return;
			end
			attempt_count = attempt_count + 16'd1;
			if (attempt_count >= retry_limit) begin
				abort_with(STAT_TIMEOUT);
			end else begin
				send(WORD_IDLE);
			end
		endfunction

		function void take_reply(logic [15:0] w);
			frame_t f;
			int     nx;
			case (phase)
				PH_WAKE: begin
					if (wake_count >= wake_words) begin
						select_level = 1'b0;
						start_frame(PH_CMD0);
					end else begin
						wake_count = wake_count + 8'd1;
						send(WORD_IDLE);
					end
					return;
				end
				PH_BUSY1, PH_BUSY2: begin
					busy_reply(w);
					return;
				end
				PH_STOP: begin
					phase         = PH_BUSY2;
					attempt_count = '0;
					send(WORD_IDLE);
					return;
				end
				PH_DATA: begin
					phase = PH_DATAWAIT;
					return;
				end
				default: ;
			endcase
			f = frame_for(phase);
			if (f == FR_NONE) begin
				abort_with(STAT_IDLE);
				return;
			end
			// R1 reply sits in the first poll
			if (word_index == 3'd3 && w != WORD_R1_IDLE) begin
				if (phase == PH_CMD0) phase = PH_CMD0_BAD;
				else if (phase == PH_ACMD41) phase = PH_ACMD_DONE;
			end
			nx = int'(word_index) + 1;
			if (nx < frame_words_in(f)) begin
				word_index = nx[2:0];
				send(frame_word_at(f, nx));
			end else begin
				frame_done();
			end
		endfunction

		// Accepted input: predict its result; returns 0 when the item is ignored
		function bit note_item(logic [2:0] m, logic [15:0] w);
			result_t want;
			bit      refused;
			bit      effect;
			bit      busy_now;
			refused  = 1'b0;
			effect   = 1'b1;
			busy_now = running();
			tx_on    = 1'b0;
			tx_val   = '0;
			case (m)
				MODE_REPLY: begin
					if (busy_now) take_reply(w);
					else effect = 1'b0;
				end
				MODE_INIT, MODE_WRITE: begin
					if (phase == PH_IDLE) begin
						status_code   = STAT_BUSY;
						attempt_count = '0;
						if (m == MODE_INIT) begin
							fast_flag    = 1'b0;
							select_level = 1'b1;
							wake_count   = 8'd1;
							word_index   = '0;
							phase        = PH_WAKE;
							send(WORD_IDLE);
						end else begin
							address_low = w;
							start_frame(PH_CMD25);
						end
					end else begin
						refused = 1'b1;
					end
				end
				MODE_DATA, MODE_END: begin
					if (phase == PH_DATAWAIT) begin
						if (m == MODE_DATA) begin
							phase = PH_DATA;
							send(w);
						end else begin
							start_frame(PH_CRC);
						end
					end else begin
						refused = 1'b1;
					end
				end
				default: effect = 1'b0;
			endcase
			if (refused) refusals++;
			want.tx_valid    = tx_on;
			want.tx_word     = tx_on ? tx_val : 16'h0000;
			want.select_high = select_level;
			want.fast_clock  = fast_flag;
			want.status      = refused ? STAT_REFUSED : status_code;
			expected_q.push_back(want);
			return effect;
		endfunction

		function void check_result(result_t got);
			result_t want;
			bit      bad;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("[%0t] result with nothing expected: %p", $realtime, got);
				return;
			end
			want = expected_q.pop_front();
			checked++;
			bad = (got.tx_valid !== want.tx_valid) || (got.tx_word !== want.tx_word) ||
				(got.select_high !== want.select_high) ||
				(got.fast_clock !== want.fast_clock) || (got.status !== want.status);
			if (bad) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display({"[%0t] result %0d: expected tx %b/%h cs %b fast %b st %0d,",
						" got tx %b/%h cs %b fast %b st %0d"},
						$realtime, checked, want.tx_valid, want.tx_word, want.select_high,
						want.fast_clock, want.status, got.tx_valid, got.tx_word,
						got.select_high, got.fast_clock, got.status);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  mode = MODE_REPLY;
	logic [15:0] word = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        tx_valid;
	logic [15:0] tx_word;
	logic        select_high;
	logic        fast_clock;
	logic [2:0]  status;

	sd_seq_scoreboard sb;

	int src_idle_pct  = 0;
	int dst_stall_pct = 0;
	int cmd0_bad_pct  = 8;
	int refuse_pct    = 0;
	int acmd_left     = 0;
	int poll_left     = 0;
	int items_in      = 0;
	int items_done    = 0;
	int inits_started = 0;
	int writes_started = 0;
	int hold_requests = 0;
	int hold_served   = 0;
	int hold_left     = 0;
	int cycle_count   = 0;

	sd_spi_init_and_write_sequencer uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.word(word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.tx_valid(tx_valid),
		.tx_word(tx_word),
		.select_high(select_high),
		.fast_clock(fast_clock),
		.status(status)
	);

	always #4 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				sb.pending());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Result side: check each transfer, then pick the next stall level
	always @(posedge clk) begin : result_side
		result_t got;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got.tx_valid    = tx_valid;
				got.tx_word     = tx_word;
				got.select_high = select_high;
				got.fast_clock  = fast_clock;
				got.status      = status;
				sb.check_result(got);
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (hold_served != hold_requests) begin
				// long hold-off so the block backs up and stalls its input
				hold_served++;
				hold_left = HOLD_CYCLES;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < dst_stall_pct);
			end
		end
	end

	function automatic logic [15:0] rand16();
		logic [31:0] r;
		r = $urandom();
		return r[15:0];
	endfunction

	// Card side: the word the card sends back for the word now in flight
	function automatic logic [15:0] card_reply();
		logic [15:0] w;
		w = rand16();
		case (sb.phase)
			PH_CMD0: if (sb.word_index == 3'd3) begin
				if ($urandom_range(0, 99) < cmd0_bad_pct) w = 16'($urandom_range(0, 16'hFF00));
				else w = WORD_R1_IDLE;
			end
			PH_ACMD41: if (sb.word_index == 3'd3) begin
				if (acmd_left > 0) begin
					acmd_left--;
					w = WORD_R1_IDLE;
				end else begin
					w = 16'($urandom_range(0, 16'hFF00));
				end
			end
			PH_BUSY1, PH_BUSY2: begin
				if (poll_left > 0) begin
					poll_left--;
					w = 16'($urandom_range(0, 16'hFFFE));
				end else begin
					w = WORD_IDLE;
				end
			end
			PH_STOP: poll_left = $urandom_range(0, 5);
			default: ;
		endcase
		return w;
	endfunction

	// One input transfer, with a random gap in front
	task automatic put_item(input logic [2:0] m, input logic [15:0] w);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode     <= m;
		word     <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_in++;
		if (sb.note_item(m, w)) items_done++;
	endtask

	// Answer every word in flight, now and then slipping in a refused command or an unused mode
	task automatic finish_sequence();
		logic [2:0] m;
		while (sb.running()) begin
			if ($urandom_range(0, 99) < refuse_pct) begin
				m = 3'($urandom_range(1, 7));
				put_item(m, rand16());
			end
			put_item(MODE_REPLY, card_reply());
		end
	endtask

	task automatic run_init();
		acmd_left = $urandom_range(0, 5);
		inits_started++;
		put_item(MODE_INIT, rand16());
		finish_sequence();
	endtask

	task automatic close_write();
		if ($urandom_range(0, 99) < 15)
			put_item($urandom_range(0, 1) ? MODE_INIT : MODE_WRITE, rand16());
		poll_left = $urandom_range(0, 5);
		put_item(MODE_END, rand16());
		finish_sequence();
	endtask

	task automatic run_write();
		int n;
		writes_started++;
		put_item(MODE_WRITE, rand16());
		finish_sequence();
		n = $urandom_range(0, 4);
		repeat (n) begin
			put_item(MODE_DATA, rand16());
			finish_sequence();
		end
		close_write();
	endtask

	// Random sequences until about count more items have been acted on
	task automatic random_traffic(input int count);
		int         pick;
		int         goal;
		logic [2:0] m;
		goal = items_done + count;
		while (items_done < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				run_init();
			end else if (pick < 85) begin
				run_write();
			end else begin
				// stray words, unused modes, or commands with nothing to act on
				m = 3'($urandom_range(0, 7));
				put_item(m, rand16());
				finish_sequence();
				if (sb.phase == PH_DATAWAIT) close_write();
			end
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, value);
		@(posedge clk);
	endtask

	initial begin
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Idle block, reset settings: commands with nothing to act on
		put_item(MODE_DATA, 16'h0000);
		put_item(MODE_END, 16'hFFFF);
		put_item(MODE_UNUSED_5, 16'h5555);
		put_item(MODE_UNUSED_6, 16'hAAAA);
		put_item(MODE_UNUSED_7, 16'hFFFF);
		put_item(MODE_REPLY, 16'h1234);
		settle();

		// Zero wake count acts as one; failed CMD0 reply still runs both polls
		write_reg(CFG_RETRY_LIMIT, 16'd1);
		write_reg(CFG_WAKE_WORDS, 16'd0);
		cmd0_bad_pct = 100;
		put_item(MODE_INIT, 16'hFFFF);
		put_item(MODE_WRITE, 16'h0000);
		put_item(MODE_INIT, 16'h0000);
		finish_sequence();
		cmd0_bad_pct = 8;

		// Write with extreme address and data; busy wait times out on the first poll
		put_item(MODE_WRITE, 16'hFFFF);
		finish_sequence();
		put_item(MODE_DATA, 16'h0000);
		finish_sequence();
		poll_left = 1;
		put_item(MODE_END, 16'h0000);
		finish_sequence();
		settle();

		// Busy sender, slow receiver; a zero retry limit acts as one
		write_reg(CFG_RETRY_LIMIT, 16'd0);
		write_reg(CFG_WAKE_WORDS, 16'd1);
		src_idle_pct  = 38;
		dst_stall_pct = 82;
		refuse_pct    = 5;
		random_traffic(100);
		settle();

		// Slow sender, busy receiver; one init with the largest settings, then short wakes
		write_reg(CFG_RETRY_LIMIT, 16'hFFFF);
		write_reg(CFG_WAKE_WORDS, 16'd255);
		src_idle_pct  = 82;
		dst_stall_pct = 38;
		run_init();
		settle();
		write_reg(CFG_WAKE_WORDS, 16'd8);
		random_traffic(50);
		settle();

		// Full rate with long receiver hold-offs; small limit so timeouts show up
		write_reg(CFG_RETRY_LIMIT, 16'd4);
		write_reg(CFG_WAKE_WORDS, 16'd16);
		src_idle_pct  = 0;
		dst_stall_pct = 0;
		hold_requests++;
		random_traffic(60);
		hold_requests++;
		random_traffic(60);
		settle();

		$display("run: %0d transfers in (%0d acted on), %0d results checked, %0d bad",
			items_in, items_done, sb.checked, sb.mismatches);
		$display({"run: %0d inits (%0d reached fast clock), %0d writes,",
			" %0d CMD0 errors, %0d timeouts, %0d refused"},
			inits_started, sb.inits_done, writes_started, sb.cmd0_errors, sb.timeouts,
			sb.refusals);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/core/sdspi_pkg.sv
rtl/core/sdspi_in_reg.sv
rtl/core/sdspi_core.sv
rtl/core/sdspi_out_reg.sv
rtl/core/sd_spi_init_and_write_sequencer.sv
tb/tb_sd_spi_init_and_write_sequencer.sv
